@@ rtl/crcfr_pkg.sv @@
`default_nettype none
package crcfr_pkg;

  // register indexes on the config port
  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_EXPECTED_CODE = 2'd0;
  localparam cfg_idx_t CFG_NORMAL_ID     = 2'd1;
  localparam cfg_idx_t CFG_STATUS_ID     = 2'd2;
  localparam cfg_idx_t CFG_NACK_CODE     = 2'd3;

  // register reset values
  localparam logic [7:0] RST_EXPECTED_CODE = 8'd0;
  localparam logic [7:0] RST_NORMAL_ID     = 8'd83;
  localparam logic [7:0] RST_STATUS_ID     = 8'd82;
  localparam logic [7:0] RST_NACK_CODE     = 8'd0;

  // end-of-frame status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_CRC   = 3'd1;
  localparam status_t ST_NACK  = 3'd2;
  localparam status_t ST_WRONG = 3'd3;
  localparam status_t ST_LEN   = 3'd4;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // commands from the front end to the back end
  typedef logic [3:0] op_code_t;
  localparam op_code_t OP_START   = 4'd0;  // data holds frame length
  localparam op_code_t OP_DATA    = 4'd1;  // crc update only
  localparam op_code_t OP_PASS    = 4'd2;  // crc update and pass byte out
  localparam op_code_t OP_CRCH    = 4'd3;  // latch received crc high byte
  localparam op_code_t OP_CHECK   = 4'd4;  // data is crc low byte, compare
  localparam op_code_t OP_STAT_OK = 4'd5;  // status frame swallowed
  localparam op_code_t OP_NACK    = 4'd6;
  localparam op_code_t OP_WRONG   = 4'd7;
  localparam op_code_t OP_LEN_ERR = 4'd8;

  typedef struct packed {
    op_code_t   op;
    logic [7:0] data;
  } op_t;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // CRC-16/XMODEM, one byte, msb first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/crcfr_in_if.sv @@
`default_nettype none
interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/crcfr_out_if.sv @@
`default_nettype none
interface crcfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [2:0] status;
  logic [5:0] content_length;
  logic       was_status_frame;

  modport source (output valid, output kind, output payload_byte, output status,
                  output content_length, output was_status_frame, input ready);
  modport sink   (input valid, input kind, input payload_byte, input status,
                  input content_length, input was_status_frame, output ready);
endinterface
`default_nettype wire

@@ rtl/crcfr_cfg_if.sv @@
`default_nettype none
interface crcfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/crcfr_front.sv @@
`default_nettype none
module crcfr_front #(
  parameter int unsigned MAX_CONTENT = 62
) (
  input  wire logic        clk,
  input  wire logic        rst,
  crcfr_in_if.sink         rx,
  crcfr_cfg_if.sink        cfg,
  output crcfr_pkg::op_t   push_item,
  output logic             push_valid,
  input  wire logic        push_ready
);
  import crcfr_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_CONTENT + 1);
  localparam logic [7:0]  MAX_B = 8'(MAX_CONTENT);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_CRCH = 3'd3;
  localparam logic [2:0] PH_CRCL = 3'd4;

  logic [7:0] expected_code, normal_id, status_id, nack_code;

  logic [2:0]       phase, phase_next;
  logic             frame_is_status, frame_is_status_next;
  logic             first, first_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic [7:0]       code_byte, code_byte_next;

  logic       accept;
  logic [7:0] b;
  logic       has_op;
  op_t        op_next;

  assign rx.ready  = push_ready;
  assign cfg.ready = 1'b1;
  assign accept    = rx.valid && rx.ready;
  assign b         = rx.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_code <= RST_EXPECTED_CODE;
      normal_id     <= RST_NORMAL_ID;
      status_id     <= RST_STATUS_ID;
      nack_code     <= RST_NACK_CODE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_EXPECTED_CODE: expected_code <= cfg.data;
        CFG_NORMAL_ID:     normal_id     <= cfg.data;
        CFG_STATUS_ID:     status_id     <= cfg.data;
        CFG_NACK_CODE:     nack_code     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next           = phase;
    frame_is_status_next = frame_is_status;
    first_next           = first;
    bytes_left_next      = bytes_left;
    code_byte_next       = code_byte;
    has_op               = 1'b0;
    op_next.op           = OP_DATA;
    op_next.data         = b;
    unique case (phase)
      PH_IDLE: begin
        if (b == normal_id) begin
          frame_is_status_next = 1'b0;
          phase_next           = PH_LEN;
        end else if (b == status_id) begin
          frame_is_status_next = 1'b1;
          phase_next           = PH_LEN;
        end else begin
          has_op     = 1'b1;
          op_next.op = OP_WRONG;
        end
      end
      PH_LEN: begin
        has_op = 1'b1;
        if (b == 8'd0 || b > MAX_B) begin
          op_next.op = OP_LEN_ERR;
          phase_next = PH_IDLE;
        end else begin
          op_next.op      = OP_START;
          bytes_left_next = b[LEN_W-1:0];
          first_next      = 1'b1;
          code_byte_next  = 8'd0;
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        has_op     = 1'b1;
        first_next = 1'b0;
        if (first) begin
          code_byte_next = b;
          op_next.op     = OP_DATA;
        end else if (!frame_is_status && code_byte == expected_code) begin
          op_next.op = OP_PASS;
        end else begin
          op_next.op = OP_DATA;
        end
        bytes_left_next = bytes_left - LEN_W'(1);
        if (bytes_left == LEN_W'(1)) begin
          phase_next = PH_CRCH;
        end
      end
      PH_CRCH: begin
        has_op     = 1'b1;
        op_next.op = OP_CRCH;
        phase_next = PH_CRCL;
      end
      PH_CRCL: begin
        has_op     = 1'b1;
        phase_next = PH_IDLE;
        if (frame_is_status) begin
          op_next.op = OP_STAT_OK;
        end else if (code_byte == expected_code) begin
          op_next.op = OP_CHECK;
        end else if (code_byte == nack_code) begin
          op_next.op = OP_NACK;
        end else begin
          op_next.op = OP_WRONG;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  assign push_valid = accept && has_op;
  assign push_item  = op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      frame_is_status <= 1'b0;
      first           <= 1'b0;
      bytes_left      <= '0;
      code_byte       <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      frame_is_status <= frame_is_status_next;
      first           <= first_next;
      bytes_left      <= bytes_left_next;
      code_byte       <= code_byte_next;
    end
  end

  // a byte is only taken when the queue has room for its command
  a_no_push_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("front pushed into a full queue");

  // data phase always has a content byte still to come
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != '0)
    else $error("data phase with zero bytes left");

  // a zero length byte always reports a length error
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_LEN && b == 8'd0 |-> push_valid && push_item.op == OP_LEN_ERR)
    else $error("zero length not reported");

endmodule
`default_nettype wire

@@ rtl/crcfr_queue.sv @@
`default_nettype none
module crcfr_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  crcfr_pkg::op_t       push_item,
  input  wire logic            push_valid,
  output logic                 push_ready,
  output crcfr_pkg::op_t       pop_item,
  output logic                 pop_valid,
  input  wire logic            pop_ready
);
  import crcfr_pkg::*;

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  op_t              mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = count != CNT_W'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("empty queue with pointers apart");

  a_single_push_fill: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + CNT_W'(1))
    else $error("push not counted");

endmodule
`default_nettype wire

@@ rtl/crcfr_back.sv @@
`default_nettype none
module crcfr_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  crcfr_pkg::op_t   pop_item,
  input  wire logic        pop_valid,
  output logic             pop_ready,
  crcfr_out_if.source      tx
);
  import crcfr_pkg::*;

  logic [15:0] running_crc;
  logic [7:0]  crc_high_byte;
  logic [5:0]  frame_length;

  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_payload;
  status_t     out_status;
  logic [5:0]  out_len;
  logic        out_wsf;

  logic        do_pop;
  logic        emit;
  logic        e_kind;
  logic [7:0]  e_payload;
  status_t     e_status;
  logic [5:0]  e_len;
  logic        e_wsf;

  assign pop_ready = !out_valid || tx.ready;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    emit      = 1'b0;
    e_kind    = KIND_STATUS;
    e_payload = 8'd0;
    e_status  = ST_OK;
    e_len     = 6'd0;
    e_wsf     = 1'b0;
    unique case (pop_item.op)
      OP_PASS: begin
        emit      = 1'b1;
        e_kind    = KIND_PAYLOAD;
        e_payload = pop_item.data;
      end
      OP_CHECK: begin
        emit = 1'b1;
        if ({crc_high_byte, pop_item.data} != running_crc) begin
          e_status = ST_CRC;
        end else begin
          e_len = frame_length;
        end
      end
      OP_STAT_OK: begin
        emit  = 1'b1;
        e_wsf = 1'b1;
      end
      OP_NACK: begin
        emit     = 1'b1;
        e_status = ST_NACK;
      end
      OP_WRONG: begin
        emit     = 1'b1;
        e_status = ST_WRONG;
      end
      OP_LEN_ERR: begin
        emit     = 1'b1;
        e_status = ST_LEN;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      unique case (pop_item.op)
        OP_START: begin
          running_crc  <= 16'd0;
          frame_length <= pop_item.data[5:0];
        end
        OP_DATA, OP_PASS: begin
          running_crc <= crc16_step(running_crc, pop_item.data);
        end
        OP_CRCH: begin
          crc_high_byte <= pop_item.data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_pop && emit) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && emit) begin
      out_kind    <= e_kind;
      out_payload <= e_payload;
      out_status  <= e_status;
      out_len     <= e_len;
      out_wsf     <= e_wsf;
    end
  end

  assign tx.valid            = out_valid;
  assign tx.kind             = out_kind;
  assign tx.payload_byte     = out_payload;
  assign tx.status           = out_status;
  assign tx.content_length   = out_len;
  assign tx.was_status_frame = out_wsf;

  // a pass command always shows up as a payload result next cycle
  a_pass_emits: assert property (@(posedge clk) disable iff (rst)
    do_pop && pop_item.op == OP_PASS |=> out_valid && out_kind == KIND_PAYLOAD)
    else $error("pass command lost");

  // a result held back by the sink is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx.ready |-> !do_pop)
    else $error("command popped over a stalled result");

  // a stalled result stays valid and unchanged
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx.ready |=> out_valid &&
      $stable({out_kind, out_payload, out_status, out_len, out_wsf}))
    else $error("stalled result changed");

endmodule
`default_nettype wire

@@ rtl/crc16_frame_receiver.sv @@
`default_nettype none
// Frame receiver: id, length, content, CRC-16/XMODEM (big-endian) over content.
// Throughput: one byte per cycle while the result side keeps up.
// A byte's command passes through the command queue, then the registered
//   result stage, before its result shows at tx.
// Reset (rst, synchronous, active high) empties the queue and output stage,
//   returns to idle and loads register defaults (normal id 83, status id 82).
module crc16_frame_receiver #(
  parameter int unsigned MAX_CONTENT = 62
) (
  input  wire logic  clk,
  input  wire logic  rst,
  crcfr_in_if.sink   rx,
  crcfr_cfg_if.sink  cfg,
  crcfr_out_if.source tx
);
  import crcfr_pkg::*;

  // Front end: phase tracking, id/length/code classification against the
  // config registers as they stand when each byte arrives. Produces at most
  // one command per byte.
  op_t  push_item;
  logic push_valid;
  logic push_ready;

  // Back end side of the two-entry command queue.
  op_t  pop_item;
  logic pop_valid;
  logic pop_ready;

  crcfr_front #(
    .MAX_CONTENT (MAX_CONTENT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .cfg        (cfg),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Queue lets the input keep flowing for a couple of bytes while the
  // result sink stalls; rx.ready drops only when it is full.
  crcfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Back end: running CRC (one byte per cycle while the result stage is not
  // stalled), received CRC compare and the registered result stage.
  crcfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .tx        (tx)
  );

  // nothing reaches the result port without a command having entered
  a_queue_fed: assert property (@(posedge clk) disable iff (rst)
    pop_valid && !$past(pop_valid) |-> $past(push_valid))
    else $error("queue became non-empty without a push");

  // input backpressure comes only from a full queue
  a_ready_track: assert property (@(posedge clk) disable iff (rst)
    rx.ready == push_ready)
    else $error("input ready does not follow queue room");

  // a fresh result is always preceded by a popped command
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(tx.valid) |-> $past(pop_valid && pop_ready))
    else $error("result without a command");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
import crcfr_pkg::*;

// Longest content the receiver takes; matches the block's default parameter.
localparam int unsigned MAX_CONTENT_LEN = 62;

typedef logic [7:0] byte_q_t[$];

typedef enum logic [2:0] {
  AWAIT_ID,
  AWAIT_LEN,
  IN_CONTENT,
  AWAIT_CRC_HI,
  AWAIT_CRC_LO
} frame_phase_t;

typedef struct packed {
  logic       kind;
  logic [7:0] payload_byte;
  status_t    status;
  logic [5:0] content_length;
  logic       was_status_frame;
} frame_result_t;

// CRC-16/XMODEM, one bit per step, msb first
function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] crc, input logic [7:0] b);
  logic [15:0] c;
  logic        fb;
  c = crc;
  for (int i = 7; i >= 0; i--) begin
    fb = c[15] ^ b[i];
    c  = {c[14:0], 1'b0};
    if (fb) begin
      c = c ^ CRC_POLY;
    end
  end
  return c;
endfunction

// Mirrors the receiver's frame state and holds the results it should produce.
class frame_scoreboard;
  logic [7:0]    expected_code;
  logic [7:0]    normal_id;
  logic [7:0]    status_id;
  logic [7:0]    nack_code;
  frame_phase_t  phase;
  bit            frame_is_status;
  logic [7:0]    frame_len;
  logic [7:0]    bytes_left;
  logic [7:0]    code_byte;
  logic [15:0]   running_crc;
  logic [7:0]    crc_hi;
  frame_result_t expected_results[$];
  int unsigned   mismatches;

  function new();
    expected_code   = RST_EXPECTED_CODE;
    normal_id       = RST_NORMAL_ID;
    status_id       = RST_STATUS_ID;
    nack_code       = RST_NACK_CODE;
    phase           = AWAIT_ID;
    frame_is_status = 1'b0;
    frame_len       = '0;
    bytes_left      = '0;
    code_byte       = '0;
    running_crc     = '0;
    crc_hi          = '0;
    mismatches      = 0;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [7:0] value);
    case (idx)
      CFG_EXPECTED_CODE: expected_code = value;
      CFG_NORMAL_ID:     normal_id = value;
      CFG_STATUS_ID:     status_id = value;
      CFG_NACK_CODE:     nack_code = value;
      default: ;
    endcase
  endfunction

  function void expect_status(status_t st, logic [5:0] len, logic from_status_frame);
    frame_result_t r;
    r                  = '0;
    r.kind             = KIND_STATUS;
    r.status           = st;
    r.content_length   = len;
    r.was_status_frame = from_status_frame;
    expected_results.push_back(r);
  endfunction

  // one received byte, taken with the register values of this moment
  function void take_byte(logic [7:0] b);
    frame_result_t r;
    case (phase)
      AWAIT_ID: begin
        if (b == normal_id) begin
          frame_is_status = 1'b0;
          phase = AWAIT_LEN;
        end else if (b == status_id) begin
          frame_is_status = 1'b1;
          phase = AWAIT_LEN;
        end else begin
          expect_status(ST_WRONG, '0, 1'b0);
        end
      end
      AWAIT_LEN: begin
        if (b == 8'd0 || b > MAX_CONTENT_LEN) begin
          phase = AWAIT_ID;
          expect_status(ST_LEN, '0, 1'b0);
        end else begin
          frame_len   = b;
          bytes_left  = b;
          running_crc = '0;
          code_byte   = '0;
          phase       = IN_CONTENT;
        end
      end
      IN_CONTENT: begin
        running_crc = crc16_xmodem_byte(running_crc, b);
        if (bytes_left == frame_len) begin
          code_byte = b;
        end else if (!frame_is_status && code_byte == expected_code) begin
          r              = '0;
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = b;
          expected_results.push_back(r);
        end
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
          phase = AWAIT_CRC_HI;
        end
      end
      AWAIT_CRC_HI: begin
        crc_hi = b;
        phase  = AWAIT_CRC_LO;
      end
      AWAIT_CRC_LO: begin
        phase = AWAIT_ID;
        if (frame_is_status) begin
          expect_status(ST_OK, '0, 1'b1);
        end else if (code_byte == expected_code) begin
          if ({crc_hi, b} != running_crc) begin
            expect_status(ST_CRC, '0, 1'b0);
          end else begin
            expect_status(ST_OK, frame_len[5:0], 1'b0);
          end
        end else if (code_byte == nack_code) begin
          expect_status(ST_NACK, '0, 1'b0);
        end else begin
          expect_status(ST_WRONG, '0, 1'b0);
        end
      end
      default: phase = AWAIT_ID;
    endcase
  endfunction

  function void check_result(frame_result_t got);
    frame_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: kind %0d payload 0x%02h status %0d",
             got.kind, got.payload_byte, got.status);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (got.kind != want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatches++;
    end
    if (got.payload_byte != want.payload_byte) begin
      $error("payload_byte: expected 0x%02h, got 0x%02h", want.payload_byte, got.payload_byte);
      mismatches++;
    end
    if (got.status != want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.content_length != want.content_length) begin
      $error("content_length: expected %0d, got %0d", want.content_length, got.content_length);
      mismatches++;
    end
    if (got.was_status_frame != want.was_status_frame) begin
      $error("was_status_frame: expected %0d, got %0d",
             want.was_status_frame, got.was_status_frame);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return expected_results.size();
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // generous limit, well above what the slowest legal run needs
  localparam int unsigned CYCLE_LIMIT = 200000;
  // cycles after the last result before registers may change or the run ends
  localparam int unsigned SETTLE_CYCLES = 8;
  // long receiver hold-off so the front queue and result stage fill up
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  crcfr_in_if  rx();
  crcfr_cfg_if cfg();
  crcfr_out_if tx();

  crc16_frame_receiver #(
    .MAX_CONTENT(MAX_CONTENT_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .cfg(cfg),
    .tx(tx)
  );

  frame_scoreboard sb;

  int unsigned idle_pct;   // chance the sender skips a cycle
  int unsigned stall_pct;  // chance the receiver drops ready
  logic        hold_rx;    // long receiver hold-off in progress
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or lost result ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: sample the handshake as it stood at the edge, then pick
  // ready for the next cycle.
  always @(posedge clk) begin : result_side
    frame_result_t got;
    if (!rst && tx.valid && tx.ready) begin
      got.kind             = tx.kind;
      got.payload_byte     = tx.payload_byte;
      got.status           = tx.status;
      got.content_length   = tx.content_length;
      got.was_status_frame = tx.was_status_frame;
      sb.check_result(got);
    end
    tx.ready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
  end

  // Offer one byte, with random idle cycles in front; valid is left high so
  // a following byte goes back to back.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) begin
      @(posedge clk);
    end
    sb.take_byte(b);
  endtask

  task automatic send_queue(input byte_q_t bytes);
    foreach (bytes[i]) begin
      send_byte(bytes[i]);
    end
  endtask

  // Drop valid, wait for every expected result, then let the no-result
  // items still in the pipe drain out.
  task automatic settle();
    rx.valid <= 1'b0;
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All four registers, back to back on the config channel.
  task automatic load_registers(input logic [7:0] exp_code, input logic [7:0] nid,
                                input logic [7:0] sid, input logic [7:0] nack);
    cfg_idx_t   idx  [4];
    logic [7:0] vals [4];
    idx  = '{CFG_EXPECTED_CODE, CFG_NORMAL_ID, CFG_STATUS_ID, CFG_NACK_CODE};
    vals = '{exp_code, nid, sid, nack};
    for (int i = 0; i < 4; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx[i];
      cfg.data  <= vals[i];
      @(posedge clk);
      while (!cfg.ready) begin
        @(posedge clk);
      end
      sb.write_reg(idx[i], vals[i]);
    end
    cfg.valid <= 1'b0;
  endtask

  // id, length, code byte plus random content, CRC with optional bit flips
  function automatic byte_q_t build_frame(input logic [7:0] id, input logic [7:0] code,
                                          input int unsigned len, input logic [15:0] crc_flip);
    byte_q_t     q;
    logic [15:0] crc;
    logic [7:0]  b;
    q.push_back(id);
    q.push_back(8'(len));
    crc = '0;
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? code : 8'($urandom_range(0, 255));
      crc = crc16_xmodem_byte(crc, b);
      q.push_back(b);
    end
    crc = crc ^ crc_flip;
    q.push_back(crc[15:8]);
    q.push_back(crc[7:0]);
    return q;
  endfunction

  // mostly short frames so many of them fit; both length extremes show up
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return MAX_CONTENT_LEN;
    if (r < 12) return 1;
    if (r < 90) return $urandom_range(2, 8);
    return $urandom_range(9, MAX_CONTENT_LEN - 1);
  endfunction

  // About half well-formed frames with random content; the rest is bad CRC,
  // nack/wrong codes, status frames, bad lengths, stray bytes and cut frames.
  task automatic send_random_traffic(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned pick;
    int unsigned cut;
    byte_q_t     frame;
    logic [7:0]  code;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_bytes) begin
      frame.delete();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        frame = build_frame(sb.normal_id, sb.expected_code, pick_length(), '0);
      end else if (pick < 58) begin
        frame = build_frame(sb.normal_id, sb.expected_code, pick_length(),
                            16'(1) << $urandom_range(0, 15));
      end else if (pick < 65) begin
        frame = build_frame(sb.normal_id, sb.nack_code, pick_length(),
                            16'($urandom_range(0, 65535)));
      end else if (pick < 72) begin
        code = 8'($urandom_range(0, 255));
        while (code == sb.expected_code || code == sb.nack_code) begin
          code = 8'($urandom_range(0, 255));
        end
        frame = build_frame(sb.normal_id, code, pick_length(), 16'($urandom_range(0, 65535)));
      end else if (pick < 82) begin
        frame = build_frame(sb.status_id, 8'($urandom_range(0, 255)), pick_length(),
                            16'($urandom_range(0, 65535)));
      end else if (pick < 88) begin
        frame.push_back($urandom_range(0, 1) ? sb.normal_id : sb.status_id);
        frame.push_back($urandom_range(0, 2) == 0 ? 8'd0
                        : 8'($urandom_range(MAX_CONTENT_LEN + 1, 255)));
      end else if (pick < 94) begin
        b = 8'($urandom_range(0, 255));
        while (b == sb.normal_id || b == sb.status_id) begin
          b = 8'($urandom_range(0, 255));
        end
        frame.push_back(b);
      end else begin
        // frame cut short: the next frame's bytes land in its content
        frame = build_frame(sb.normal_id, sb.expected_code, pick_length(), '0);
        cut = $urandom_range(1, frame.size() - 1);
        repeat (cut) void'(frame.pop_back());
      end
      send_queue(frame);
      sent += frame.size();
    end
  endtask

  task automatic hold_receiver(input int unsigned n_cycles);
    hold_rx <= 1'b1;
    repeat (n_cycles) @(posedge clk);
    hold_rx <= 1'b0;
  endtask

  initial begin : main_flow
    byte_q_t    frame;
    logic [7:0] shared_code;

    sb          = new();
    idle_pct    = 0;
    stall_pct   = 0;
    hold_rx     = 1'b0;
    rst         = 1'b1;
    rx.valid    = 1'b0;
    rx.rx_byte  = '0;
    cfg.valid   = 1'b0;
    cfg.index   = CFG_EXPECTED_CODE;
    cfg.data    = '0;
    tx.ready    = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset register values ---
    // stray bytes at both ends of the range: unknown id
    send_byte(8'h00);
    send_byte(8'hFF);
    // zero length on a status frame, one over the limit on a normal frame
    send_byte(sb.status_id);
    send_byte(8'd0);
    send_byte(sb.normal_id);
    send_byte(8'(MAX_CONTENT_LEN + 1));
    // status frame is swallowed, CRC ignored
    send_queue(build_frame(sb.status_id, 8'h77, 1, 16'hA5A5));
    // expected code equals nack code here: expected code wins, payload passes
    send_queue(build_frame(sb.normal_id, sb.expected_code, 2, '0));
    settle();

    // same id for both frame kinds: opens a normal frame
    load_registers(8'h5A, 8'h7E, 8'h7E, 8'h00);
    // CRC failure after a payload byte has already gone out
    send_queue(build_frame(8'h7E, 8'h5A, 2, 16'h0001));
    // expected code changed in mid-frame, after the code byte
    frame = build_frame(8'h7E, 8'h5A, 2, '0);
    for (int i = 0; i < 3; i++) begin
      send_byte(frame[i]);
    end
    settle();
    load_registers(8'h11, 8'h7E, 8'h7E, 8'h00);
    for (int i = 3; i < frame.size(); i++) begin
      send_byte(frame[i]);
    end
    settle();

    // --- random, no idling ---
    load_registers(8'hC3, RST_NORMAL_ID, RST_STATUS_ID, 8'hE0);
    send_random_traffic(160);
    settle();

    // --- random, sender idle about half the time, registers at extremes ---
    idle_pct  = 49;
    stall_pct = 0;
    load_registers(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_random_traffic(160);
    settle();

    // --- random, receiver stalling, opposite extremes ---
    idle_pct  = 0;
    stall_pct = 49;
    load_registers(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_random_traffic(160);
    settle();

    // --- random, both sides idling; expected code equals nack code ---
    idle_pct    = 37;
    stall_pct   = 37;
    shared_code = 8'($urandom_range(0, 255));
    load_registers(shared_code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   shared_code);
    send_random_traffic(160);
    settle();

    // --- backpressure: receiver holds off while the sender keeps offering ---
    idle_pct  = 0;
    stall_pct = 0;
    load_registers(8'($urandom_range(0, 255)), RST_NORMAL_ID, RST_STATUS_ID,
                   8'($urandom_range(0, 255)));
    fork
      hold_receiver(HOLD_CYCLES);
      send_random_traffic(60);
    join
    settle();

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
